FILE: design/durs_pkg.sv
package durs_pkg;

    // operation codes of an input transaction
    localparam logic [1:0] OP_QUERY   = 2'd0;
    localparam logic [1:0] OP_REPLY   = 2'd1;
    localparam logic [1:0] OP_TIMEOUT = 2'd2;

    // domain list match classes
    localparam logic [1:0] CLS_NONE     = 2'd0;
    localparam logic [1:0] CLS_BLOCKED  = 2'd1;
    localparam logic [1:0] CLS_DOMESTIC = 2'd2;
    localparam logic [1:0] CLS_UNUSED   = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_FAIR_MODE      = 2'd0;
    localparam logic [1:0] CFG_DROP_IPV6      = 2'd1;
    localparam logic [1:0] CFG_TRUSTED_REPEAT = 2'd2;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 8;

    typedef enum logic [3:0] {
        ST_REFUSED     = 4'd0,
        ST_ECHOED      = 4'd1,
        ST_FORWARDED   = 4'd2,
        ST_SEND_THIS   = 4'd3,
        ST_SEND_HELD   = 4'd4,
        ST_FILTER_WAIT = 4'd5,
        ST_HELD        = 4'd6,
        ST_IGNORED     = 4'd7,
        ST_UNKNOWN     = 4'd8,
        ST_TIMED_OUT   = 4'd9,
        ST_STALE       = 4'd10,
        ST_DROPPED     = 4'd11
    } status_t;

    // pending query entry, 52 bits
    typedef struct packed {
        logic [15:0] held_handle;
        logic        held_valid;
        logic        dom_seen;
        logic [1:0]  match_class;
        logic [15:0] client_tag;
        logic [15:0] origin_id;
    } entry_t;

    // controller to datapath
    typedef struct packed {
        logic clear;
        logic capture;
        logic read;
        logic exec;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic out_free;
    } dp_status_t;

endpackage

FILE: design/dual_upstream_reply_selector.sv
// pending-query table for a resolver that forwards each client query to a domestic
// and a trusted upstream and picks which reply goes back. a query transaction takes
// the next rolling unique id (refused while that slot is still live) and reports the
// copy counts per server; reply and timeout transactions look the id up, decide by
// the stored match class and flags, and free the slot when done. one transaction at
// a time, the next is not accepted until the last has executed: capture at the
// accepting edge, registered table read, then read-modify-write of the table with
// the result loaded into the output register, which raises m_valid. the execute
// step waits only while a previous result is still waiting on m_ready. after reset
// the live-slot table is cleared one slot per cycle with s_ready low; configuration
// writes are taken at any time and must only occur while idle.
module dual_upstream_reply_selector
    import durs_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // input transaction channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_opcode,
    input  logic                  s_packet_ok,
    input  logic [15:0]           s_client_msg_id,
    input  logic [15:0]           s_lookup_id,
    input  logic [1:0]            s_match_class,
    input  logic                  s_is_aaaa,
    input  logic                  s_from_domestic,
    input  logic                  s_reply_accept,
    input  logic [15:0]           s_client_tag,
    input  logic [15:0]           s_reply_handle,
    // result transaction channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [3:0]            m_status,
    output logic [15:0]           m_unique_id,
    output logic [15:0]           m_origin_id,
    output logic [15:0]           m_client_out,
    output logic [15:0]           m_send_handle,
    output logic                  m_domestic_copies,
    output logic [7:0]            m_trusted_copies
);

    ctrl_cmd_t  cmd;
    dp_status_t dp_status;

    // sequencer: clear pass, accept, table read, execute
    durs_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    // table memories, id counter, decision logic and output register
    durs_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .dp_status         (dp_status),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_opcode          (s_opcode),
        .s_packet_ok       (s_packet_ok),
        .s_client_msg_id   (s_client_msg_id),
        .s_lookup_id       (s_lookup_id),
        .s_match_class     (s_match_class),
        .s_is_aaaa         (s_is_aaaa),
        .s_from_domestic   (s_from_domestic),
        .s_reply_accept    (s_reply_accept),
        .s_client_tag      (s_client_tag),
        .s_reply_handle    (s_reply_handle),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_unique_id       (m_unique_id),
        .m_origin_id       (m_origin_id),
        .m_client_out      (m_client_out),
        .m_send_handle     (m_send_handle),
        .m_domestic_copies (m_domestic_copies),
        .m_trusted_copies  (m_trusted_copies)
    );

endmodule

FILE: design/durs_ctrl.sv
module durs_ctrl
    import durs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t dp_status,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_READ  = 4'b0100,
        S_EXEC  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_ready     = 1'b0;
        cmd         = '0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clear = 1'b1;
                if (dp_status.clear_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
                if (s_valid) begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                cmd.read   = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                // wait for the output register to take the result
                if (dp_status.out_free) begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

FILE: design/durs_datapath.sv
module durs_datapath
    import durs_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ctrl_cmd_t             cmd,
    output dp_status_t            dp_status,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [1:0]            s_opcode,
    input  logic                  s_packet_ok,
    input  logic [15:0]           s_client_msg_id,
    input  logic [15:0]           s_lookup_id,
    input  logic [1:0]            s_match_class,
    input  logic                  s_is_aaaa,
    input  logic                  s_from_domestic,
    input  logic                  s_reply_accept,
    input  logic [15:0]           s_client_tag,
    input  logic [15:0]           s_reply_handle,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [3:0]            m_status,
    output logic [15:0]           m_unique_id,
    output logic [15:0]           m_origin_id,
    output logic [15:0]           m_client_out,
    output logic [15:0]           m_send_handle,
    output logic                  m_domestic_copies,
    output logic [7:0]            m_trusted_copies
);

    localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);

    // configuration
    logic       fair_mode_reg, fair_mode_next;
    logic       drop_ipv6_reg, drop_ipv6_next;
    logic [7:0] trusted_repeat_reg, trusted_repeat_next;

    // captured transaction
    logic [1:0]  op_reg;
    logic        ok_reg;
    logic [15:0] cmid_reg;
    logic [15:0] lid_reg;
    logic [1:0]  cls_reg;
    logic        aaaa_reg;
    logic        dom_reg;
    logic        acc_reg;
    logic [15:0] ctag_reg;
    logic [15:0] rh_reg;

    // table state
    logic [IDX_W-1:0] next_id_reg, next_id_next;
    logic [IDX_W-1:0] clr_idx_reg, clr_idx_next;
    logic             live_mem [TABLE_DEPTH];
    entry_t           entry_mem [TABLE_DEPTH];
    logic             live_rd_reg;
    entry_t           entry_rd_reg;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic [3:0]  status_reg;
    logic [15:0] unique_id_reg;
    logic [15:0] origin_id_reg;
    logic [15:0] client_out_reg;
    logic [15:0] send_handle_reg;
    logic        dom_copies_reg;
    logic [7:0]  trusted_copies_reg;

    // execute stage results
    logic [IDX_W-1:0] addr;
    logic [1:0]       cls_n;
    logic             in_range;
    logic [IDX_W:0]   id_inc;
    status_t          st;
    logic [15:0]      uid, oid, cout, sh;
    logic             dc;
    logic [7:0]       tc;
    logic             live_we, live_wd, ent_we, adv;
    entry_t           ent_wd;

    always_comb begin
        fair_mode_next      = fair_mode_reg;
        drop_ipv6_next      = drop_ipv6_reg;
        trusted_repeat_next = trusted_repeat_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_FAIR_MODE:      fair_mode_next = cfg_wdata[0];
                CFG_DROP_IPV6:      drop_ipv6_next = cfg_wdata[0];
                CFG_TRUSTED_REPEAT: trusted_repeat_next = cfg_wdata;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fair_mode_reg      <= 1'b0;
            drop_ipv6_reg      <= 1'b1;
            trusted_repeat_reg <= 8'd1;
            next_id_reg        <= '0;
            clr_idx_reg        <= '0;
            m_valid_reg        <= 1'b0;
        end else begin
            fair_mode_reg      <= fair_mode_next;
            drop_ipv6_reg      <= drop_ipv6_next;
            trusted_repeat_reg <= trusted_repeat_next;
            next_id_reg        <= next_id_next;
            clr_idx_reg        <= clr_idx_next;
            m_valid_reg        <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg   <= s_opcode;
            ok_reg   <= s_packet_ok;
            cmid_reg <= s_client_msg_id;
            lid_reg  <= s_lookup_id;
            cls_reg  <= s_match_class;
            aaaa_reg <= s_is_aaaa;
            dom_reg  <= s_from_domestic;
            acc_reg  <= s_reply_accept;
            ctag_reg <= s_client_tag;
            rh_reg   <= s_reply_handle;
        end
    end

    assign addr     = (op_reg == OP_QUERY) ? next_id_reg : lid_reg[IDX_W-1:0];
    assign cls_n    = (cls_reg == CLS_UNUSED) ? CLS_NONE : cls_reg;
    assign in_range = (17'(lid_reg) < 17'(TABLE_DEPTH));
    assign id_inc   = {1'b0, next_id_reg} + (IDX_W+1)'(1);

    always_ff @(posedge aclk) begin
        if (cmd.clear) begin
            live_mem[clr_idx_reg] <= 1'b0;
        end else if (cmd.exec && live_we) begin
            live_mem[addr] <= live_wd;
        end
        if (cmd.read) begin
            live_rd_reg <= live_mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec && ent_we) begin
            entry_mem[addr] <= ent_wd;
        end
        if (cmd.read) begin
            entry_rd_reg <= entry_mem[addr];
        end
    end

    assign clr_idx_next = cmd.clear ? clr_idx_reg + IDX_W'(1) : clr_idx_reg;
    assign dp_status.clear_last = (clr_idx_reg == IDX_W'(TABLE_DEPTH - 1));

    always_comb begin
        st      = ST_IGNORED;
        uid     = '0;
        oid     = '0;
        cout    = '0;
        sh      = '0;
        dc      = 1'b0;
        tc      = '0;
        live_we = 1'b0;
        live_wd = 1'b0;
        ent_we  = 1'b0;
        ent_wd  = entry_rd_reg;
        adv     = 1'b0;
        case (op_reg)
            OP_QUERY: begin
                if (live_rd_reg) begin
                    st = ST_REFUSED;
                end else if (!ok_reg) begin
                    st = ST_DROPPED;
                end else begin
                    adv  = 1'b1;
                    uid  = 16'(next_id_reg);
                    oid  = cmid_reg;
                    cout = ctag_reg;
                    if (drop_ipv6_reg && aaaa_reg) begin
                        st = ST_ECHOED;
                    end else begin
                        st                 = ST_FORWARDED;
                        ent_we             = 1'b1;
                        ent_wd.held_handle = '0;
                        ent_wd.held_valid  = 1'b0;
                        ent_wd.dom_seen    = !fair_mode_reg;
                        ent_wd.match_class = cls_n;
                        ent_wd.client_tag  = ctag_reg;
                        ent_wd.origin_id   = cmid_reg;
                        live_we            = 1'b1;
                        live_wd            = 1'b1;
                        dc = (cls_n != CLS_BLOCKED);
                        tc = (cls_n == CLS_DOMESTIC) ? 8'd0 : trusted_repeat_reg;
                    end
                end
            end
            OP_REPLY: begin
                uid = lid_reg;
                if (!ok_reg || !in_range || !live_rd_reg) begin
                    st = ST_UNKNOWN;
                end else begin
                    oid  = entry_rd_reg.origin_id;
                    cout = entry_rd_reg.client_tag;
                    if (dom_reg) begin
                        if (entry_rd_reg.match_class == CLS_DOMESTIC || acc_reg) begin
                            st      = ST_SEND_THIS;
                            sh      = rh_reg;
                            live_we = 1'b1;
                        end else if (entry_rd_reg.held_valid) begin
                            st      = ST_SEND_HELD;
                            sh      = entry_rd_reg.held_handle;
                            live_we = 1'b1;
                        end else begin
                            st              = ST_FILTER_WAIT;
                            ent_we          = 1'b1;
                            ent_wd.dom_seen = 1'b1;
                        end
                    end else begin
                        if (entry_rd_reg.match_class == CLS_BLOCKED
                            || entry_rd_reg.dom_seen) begin
                            st      = ST_SEND_THIS;
                            sh      = rh_reg;
                            live_we = 1'b1;
                        end else if (entry_rd_reg.held_valid) begin
                            st = ST_IGNORED;
                        end else begin
                            st                 = ST_HELD;
                            ent_we             = 1'b1;
                            ent_wd.held_valid  = 1'b1;
                            ent_wd.held_handle = rh_reg;
                        end
                    end
                end
            end
            OP_TIMEOUT: begin
                uid = lid_reg;
                if (in_range && live_rd_reg) begin
                    st      = ST_TIMED_OUT;
                    live_we = 1'b1;
                end else begin
                    st = ST_STALE;
                end
            end
            default: begin
                st = ST_IGNORED;
            end
        endcase
    end

    always_comb begin
        next_id_next = next_id_reg;
        if (cmd.exec && adv) begin
            next_id_next = (id_inc >= (IDX_W+1)'(TABLE_DEPTH)) ? '0 : id_inc[IDX_W-1:0];
        end
    end

    assign dp_status.out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.exec) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            status_reg         <= st;
            unique_id_reg      <= uid;
            origin_id_reg      <= oid;
            client_out_reg     <= cout;
            send_handle_reg    <= sh;
            dom_copies_reg     <= dc;
            trusted_copies_reg <= tc;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = status_reg;
    assign m_unique_id       = unique_id_reg;
    assign m_origin_id       = origin_id_reg;
    assign m_client_out      = client_out_reg;
    assign m_send_handle     = send_handle_reg;
    assign m_domestic_copies = dom_copies_reg;
    assign m_trusted_copies  = trusted_copies_reg;

endmodule

FILE: test/tb_dual_upstream_reply_selector.sv
module tb_dual_upstream_reply_selector;
    timeunit 1ns;
    timeprecision 1ps;

    import durs_pkg::*;

    localparam int unsigned TBL_DEPTH       = 1024;
    // clearing pass after reset covers the whole table, hold-off and long gaps are far shorter
    localparam int unsigned WATCHDOG_LIMIT  = 5000;
    localparam int unsigned HOLD_OFF_CYCLES = 200;
    // settle time after the last owed result, leave some margin
    localparam int unsigned DRAIN_CYCLES    = 8;
    localparam int unsigned MAX_PRINTS      = 40;
    localparam int unsigned RECENT_DEPTH    = 48;
    // opcode outside the defined set
    localparam logic [1:0]  OP_UNUSED       = 2'd3;

    // one input transaction, field order matches the s_ payload ports
    typedef struct packed {
        logic [1:0]  opcode;
        logic        packet_ok;
        logic [15:0] client_msg_id;
        logic [15:0] lookup_id;
        logic [1:0]  match_class;
        logic        is_aaaa;
        logic        from_domestic;
        logic        reply_accept;
        logic [15:0] client_tag;
        logic [15:0] reply_handle;
    } pkt_txn_t;

    // one result transaction, field order matches the m_ payload ports
    typedef struct packed {
        status_t     status;
        logic [15:0] unique_id;
        logic [15:0] origin_id;
        logic [15:0] client_out;
        logic [15:0] send_handle;
        logic        domestic_copies;
        logic [7:0]  trusted_copies;
    } verdict_t;

    // pending-query table mirror plus the verdicts still owed by the block
    class selector_scoreboard;
        int unsigned next_slot;
        bit          slot_live [TBL_DEPTH];
        entry_t      slots [TBL_DEPTH];
        bit          fair_mode;
        bit          drop_ipv6;
        bit [7:0]    trusted_repeat;
        verdict_t    expected_q [$];
        int unsigned recent_slots [$];
        int unsigned refused_cnt;
        int unsigned errors;
        int unsigned checked;

        function new();
            next_slot      = 0;
            fair_mode      = 1'b0;
            drop_ipv6      = 1'b1;
            trusted_repeat = 8'd1;
        endfunction

        function void set_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_FAIR_MODE:      fair_mode = val[0];
                CFG_DROP_IPV6:      drop_ipv6 = val[0];
                CFG_TRUSTED_REPEAT: trusted_repeat = val;
                default: ;
            endcase
        endfunction

        // note an accepted input transaction and queue the verdict it must produce
        function void predict_verdict(pkt_txn_t p);
            verdict_t    v;
            logic [1:0]  cls;
            int unsigned slot;
            entry_t      e;
            v = '0;
            v.status = ST_IGNORED;
            cls = (p.match_class == CLS_UNUSED) ? CLS_NONE : p.match_class;
            case (p.opcode)
                OP_QUERY: begin
                    slot = next_slot;
                    if (slot_live[slot]) begin
                        v.status = ST_REFUSED;
                        refused_cnt++;
                    end else if (!p.packet_ok) begin
                        v.status = ST_DROPPED;
                    end else begin
                        next_slot = (slot == TBL_DEPTH - 1) ? 0 : slot + 1;
                        v.unique_id  = 16'(slot);
                        v.origin_id  = p.client_msg_id;
                        v.client_out = p.client_tag;
                        if (drop_ipv6 && p.is_aaaa) begin
                            v.status = ST_ECHOED;
                        end else begin
                            e = '0;
                            e.origin_id   = p.client_msg_id;
                            e.client_tag  = p.client_tag;
                            e.match_class = cls;
                            e.dom_seen    = !fair_mode;
                            slots[slot]     = e;
                            slot_live[slot] = 1'b1;
                            v.status          = ST_FORWARDED;
                            v.domestic_copies = (cls != CLS_BLOCKED);
                            v.trusted_copies  = (cls == CLS_DOMESTIC) ? 8'd0 : trusted_repeat;
                            recent_slots.push_back(slot);
                            if (recent_slots.size() > RECENT_DEPTH) void'(recent_slots.pop_front());
                        end
                    end
                end
                OP_REPLY: begin
                    v.unique_id = p.lookup_id;
                    slot = p.lookup_id;
                    if (!p.packet_ok || slot >= TBL_DEPTH || !slot_live[slot]) begin
                        v.status = ST_UNKNOWN;
                    end else begin
                        e = slots[slot];
                        v.origin_id  = e.origin_id;
                        v.client_out = e.client_tag;
                        if (p.from_domestic) begin
                            if (e.match_class == CLS_DOMESTIC || p.reply_accept) begin
                                v.status        = ST_SEND_THIS;
                                v.send_handle   = p.reply_handle;
                                slot_live[slot] = 1'b0;
                            end else if (e.held_valid) begin
                                v.status        = ST_SEND_HELD;
                                v.send_handle   = e.held_handle;
                                slot_live[slot] = 1'b0;
                            end else begin
                                e.dom_seen  = 1'b1;
                                slots[slot] = e;
                                v.status    = ST_FILTER_WAIT;
                            end
                        end else begin
                            if (e.match_class == CLS_BLOCKED || e.dom_seen) begin
                                v.status        = ST_SEND_THIS;
                                v.send_handle   = p.reply_handle;
                                slot_live[slot] = 1'b0;
                            end else if (e.held_valid) begin
                                v.status = ST_IGNORED;
                            end else begin
                                e.held_valid  = 1'b1;
                                e.held_handle = p.reply_handle;
                                slots[slot]   = e;
                                v.status      = ST_HELD;
                            end
                        end
                    end
                end
                OP_TIMEOUT: begin
                    v.unique_id = p.lookup_id;
                    slot = p.lookup_id;
                    if (slot < TBL_DEPTH && slot_live[slot]) begin
                        slot_live[slot] = 1'b0;
                        v.status = ST_TIMED_OUT;
                    end else begin
                        v.status = ST_STALE;
                    end
                end
                default: v.status = ST_IGNORED;
            endcase
            expected_q.push_back(v);
        endfunction

        task flag_mismatch(string msg);
            errors++;
            if (errors <= MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        task check_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                flag_mismatch($sformatf("result %0d %s got %0h want %0h", checked, name, got, want));
        endtask

        // compare an accepted result with the oldest verdict owed
        task check_verdict(verdict_t got);
            verdict_t want;
            checked++;
            if (expected_q.size() == 0) begin
                flag_mismatch($sformatf("result %0d status %0h with nothing pending",
                                        checked, got.status));
                return;
            end
            want = expected_q.pop_front();
            check_field("status", 16'(got.status), 16'(want.status));
            check_field("unique_id", got.unique_id, want.unique_id);
            check_field("origin_id", got.origin_id, want.origin_id);
            check_field("client_out", got.client_out, want.client_out);
            check_field("send_handle", got.send_handle, want.send_handle);
            check_field("domestic_copies", 16'(got.domestic_copies), 16'(want.domestic_copies));
            check_field("trusted_copies", 16'(got.trusted_copies), 16'(want.trusted_copies));
        endtask
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic [1:0]            s_opcode;
    logic                  s_packet_ok;
    logic [15:0]           s_client_msg_id;
    logic [15:0]           s_lookup_id;
    logic [1:0]            s_match_class;
    logic                  s_is_aaaa;
    logic                  s_from_domestic;
    logic                  s_reply_accept;
    logic [15:0]           s_client_tag;
    logic [15:0]           s_reply_handle;
    logic                  m_valid;
    logic                  m_ready;
    logic [3:0]            m_status;
    logic [15:0]           m_unique_id;
    logic [15:0]           m_origin_id;
    logic [15:0]           m_client_out;
    logic [15:0]           m_send_handle;
    logic                  m_domestic_copies;
    logic [7:0]            m_trusted_copies;

    selector_scoreboard sb;
    bit                 send_idle_en;
    bit                 recv_idle_en;
    bit                 hold_off_req;
    int unsigned        quiet_cycles;
    pkt_txn_t           seen_pkt;
    verdict_t           seen_verdict;

    dual_upstream_reply_selector #(
        .TABLE_DEPTH (TBL_DEPTH)
    ) i_dut (.*);

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // gap length: mostly none, some short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // reply/timeout target: mostly recently forwarded slots, some at the slot
    // blocking the next query, the rest anywhere in or out of the table
    function automatic logic [15:0] pick_lookup();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 75 && sb.recent_slots.size() != 0)
            return 16'(sb.recent_slots[$urandom_range(0, sb.recent_slots.size() - 1)]);
        if (r < 85) return 16'(sb.next_slot);
        if (r < 93) return 16'($urandom_range(0, TBL_DEPTH - 1));
        return 16'($urandom);
    endfunction

    function automatic pkt_txn_t mk_pkt(logic [1:0] op, logic ok, logic [15:0] lid,
                                         logic [1:0] cls, logic aaaa, logic dom, logic acc);
        pkt_txn_t p;
        p.opcode        = op;
        p.packet_ok     = ok;
        p.client_msg_id = 16'($urandom);
        p.lookup_id     = lid;
        p.match_class   = cls;
        p.is_aaaa       = aaaa;
        p.from_domestic = dom;
        p.reply_accept  = acc;
        p.client_tag    = 16'($urandom);
        p.reply_handle  = 16'($urandom);
        return p;
    endfunction

    // fill mode is nearly all good queries so the table wraps onto live slots
    function automatic pkt_txn_t random_pkt(bit fill);
        pkt_txn_t    p;
        int unsigned r;
        p = mk_pkt(OP_QUERY, 1'b1, 16'($urandom), 2'($urandom_range(0, 2)), 1'($urandom),
                   1'($urandom), 1'($urandom));
        r = $urandom_range(0, 99);
        if (fill ? r < 94 : r < 38) begin
            p.opcode    = OP_QUERY;
            p.packet_ok = fill ? ($urandom_range(0, 49) != 0) : ($urandom_range(0, 19) != 0);
            if ($urandom_range(0, 15) == 0) p.match_class = CLS_UNUSED;
            p.is_aaaa   = ($urandom_range(0, 3) == 0);
        end else if (fill ? r < 97 : r < 78) begin
            p.opcode    = OP_REPLY;
            p.lookup_id = pick_lookup();
            p.packet_ok = ($urandom_range(0, 19) != 0);
        end else if (fill || r < 97) begin
            p.opcode    = OP_TIMEOUT;
            p.lookup_id = pick_lookup();
        end else begin
            p.opcode = OP_UNUSED;
        end
        return p;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_pkt(input pkt_txn_t p);
        int unsigned n;
        n = send_idle_en ? pick_gap() : 0;
        if (n != 0) begin
            s_valid <= 1'b0;
            repeat (n) @(negedge aclk);
        end
        {s_opcode, s_packet_ok, s_client_msg_id, s_lookup_id, s_match_class, s_is_aaaa,
         s_from_domestic, s_reply_accept, s_client_tag, s_reply_handle} <= p;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        sb.set_config(idx, val);
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    // stop offering, wait for every owed result, then let the pipeline settle
    task automatic finish_phase();
        s_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic run_random(input int unsigned count, input bit fill);
        for (int unsigned i = 0; i < count; i++) begin
            // once the wrap has been refused often enough the fill has done its job
            if (fill && sb.refused_cnt >= 24) break;
            send_pkt(random_pkt(fill));
        end
    endtask

    // monitor and watchdog: input transactions feed the predictor, results are checked
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                seen_pkt = {s_opcode, s_packet_ok, s_client_msg_id, s_lookup_id, s_match_class,
                            s_is_aaaa, s_from_domestic, s_reply_accept, s_client_tag,
                            s_reply_handle};
                sb.predict_verdict(seen_pkt);
            end
            if (m_valid && m_ready) begin
                seen_verdict = {m_status, m_unique_id, m_origin_id, m_client_out, m_send_handle,
                                m_domestic_copies, m_trusted_copies};
                sb.check_verdict(seen_verdict);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("FAIL dual_upstream_reply_selector");
                    $finish;
                end
            end
        end
    end

    // result receiver: random back-pressure, plus one long hold-off on request
    initial begin : receiver
        int unsigned n;
        m_ready <= 1'b0;
        @(negedge aclk);
        while (!aresetn) @(negedge aclk);
        forever begin
            if (hold_off_req) begin
                // block stalls its input while the sender keeps offering
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
                hold_off_req = 1'b0;
            end else begin
                n = recv_idle_en ? pick_gap() : 0;
                if (n != 0) begin
                    m_ready <= 1'b0;
                    repeat (n) @(negedge aclk);
                end
                m_ready <= 1'b1;
                @(posedge aclk);
                while (!m_valid) @(posedge aclk);
                @(negedge aclk);
            end
        end
    end

    initial begin : stimulus
        pkt_txn_t    p;
        logic [15:0] b;
        sb = new();
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
        hold_off_req = 1'b0;
        quiet_cycles = 0;
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        s_valid   <= 1'b0;
        {s_opcode, s_packet_ok, s_client_msg_id, s_lookup_id, s_match_class, s_is_aaaa,
         s_from_domestic, s_reply_accept, s_client_tag, s_reply_handle} <= '0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset values written explicitly: fair off, aaaa echo on, one trusted copy
        write_cfg(CFG_FAIR_MODE, 8'd0);
        write_cfg(CFG_DROP_IPV6, 8'd1);
        write_cfg(CFG_TRUSTED_REPEAT, 8'd1);

        // directed, first part: query outcomes and replies with domestic seen preset
        b = 16'(sb.next_slot);
        send_pkt(mk_pkt(OP_QUERY, 1'b0, 16'd0, CLS_NONE, 1'b0, 1'b0, 1'b0));   // bad query
        p = mk_pkt(OP_QUERY, 1'b1, 16'hFFFF, CLS_NONE, 1'b1, 1'b1, 1'b1);       // aaaa echo
        p.client_msg_id = 16'hFFFF;
        p.client_tag    = 16'hFFFF;
        p.reply_handle  = 16'hFFFF;
        send_pkt(p);
        p = mk_pkt(OP_QUERY, 1'b1, 16'd0, CLS_NONE, 1'b0, 1'b0, 1'b0);
        p.client_msg_id = 16'd0;
        p.client_tag    = 16'd0;
        p.reply_handle  = 16'd0;
        send_pkt(p);
        send_pkt(mk_pkt(OP_QUERY, 1'b1, 16'd0, CLS_BLOCKED, 1'b0, 1'b0, 1'b0));
        send_pkt(mk_pkt(OP_QUERY, 1'b1, 16'd0, CLS_DOMESTIC, 1'b0, 1'b0, 1'b0));
        send_pkt(mk_pkt(OP_QUERY, 1'b1, 16'd0, CLS_UNUSED, 1'b0, 1'b0, 1'b0));
        // short reply, out-of-table id, echoed (never live) id
        send_pkt(mk_pkt(OP_REPLY, 1'b0, b + 16'd1, CLS_NONE, 1'b0, 1'b0, 1'b1));
        send_pkt(mk_pkt(OP_REPLY, 1'b1, 16'hFFFF, CLS_NONE, 1'b0, 1'b1, 1'b1));
        send_pkt(mk_pkt(OP_REPLY, 1'b1, b, CLS_NONE, 1'b0, 1'b1, 1'b1));
        // trusted reply goes straight out, domestic class and accepted domestic replies too
        send_pkt(mk_pkt(OP_REPLY, 1'b1, b + 16'd1, CLS_NONE, 1'b0, 1'b0, 1'b0));
        send_pkt(mk_pkt(OP_REPLY, 1'b1, b + 16'd3, CLS_NONE, 1'b0, 1'b1, 1'b0));
        send_pkt(mk_pkt(OP_REPLY, 1'b1, b + 16'd2, CLS_NONE, 1'b0, 1'b1, 1'b1));
        // unused class stored as no match: rejected domestic reply waits
        send_pkt(mk_pkt(OP_REPLY, 1'b1, b + 16'd4, CLS_NONE, 1'b0, 1'b1, 1'b0));
        send_pkt(mk_pkt(OP_TIMEOUT, 1'b1, b + 16'd4, CLS_NONE, 1'b0, 1'b0, 1'b0));
        send_pkt(mk_pkt(OP_TIMEOUT, 1'b1, b + 16'd4, CLS_NONE, 1'b0, 1'b0, 1'b0)); // stale
        send_pkt(mk_pkt(OP_TIMEOUT, 1'b1, 16'hFFFF, CLS_NONE, 1'b0, 1'b0, 1'b0));
        send_pkt(mk_pkt(OP_UNUSED, 1'b1, 16'd0, CLS_NONE, 1'b0, 1'b0, 1'b0));
        finish_phase();

        // directed, second part: fair mode, held trusted replies, aaaa forwarded
        write_cfg(CFG_FAIR_MODE, 8'd1);
        write_cfg(CFG_DROP_IPV6, 8'd0);
        write_cfg(CFG_TRUSTED_REPEAT, 8'd255);
        b = 16'(sb.next_slot);
        send_pkt(mk_pkt(OP_QUERY, 1'b1, 16'd0, CLS_NONE, 1'b1, 1'b0, 1'b0));
        send_pkt(mk_pkt(OP_QUERY, 1'b1, 16'd0, CLS_BLOCKED, 1'b0, 1'b0, 1'b0));
        send_pkt(mk_pkt(OP_QUERY, 1'b1, 16'd0, CLS_NONE, 1'b0, 1'b0, 1'b0));
        send_pkt(mk_pkt(OP_REPLY, 1'b1, b, CLS_NONE, 1'b0, 1'b0, 1'b0));         // held
        send_pkt(mk_pkt(OP_REPLY, 1'b1, b, CLS_NONE, 1'b0, 1'b0, 1'b0));         // second one
        send_pkt(mk_pkt(OP_REPLY, 1'b1, b, CLS_NONE, 1'b0, 1'b1, 1'b0));         // held goes out
        send_pkt(mk_pkt(OP_REPLY, 1'b1, b + 16'd1, CLS_NONE, 1'b0, 1'b1, 1'b0));
        send_pkt(mk_pkt(OP_REPLY, 1'b1, b + 16'd1, CLS_NONE, 1'b0, 1'b0, 1'b0));
        send_pkt(mk_pkt(OP_REPLY, 1'b1, b + 16'd2, CLS_NONE, 1'b0, 1'b1, 1'b0));
        send_pkt(mk_pkt(OP_REPLY, 1'b1, b + 16'd2, CLS_NONE, 1'b0, 1'b0, 1'b0)); // seen now
        finish_phase();

        // random, no idling on either side
        write_cfg(CFG_FAIR_MODE, 8'd0);
        write_cfg(CFG_DROP_IPV6, 8'd1);
        write_cfg(CFG_TRUSTED_REPEAT, 8'd1);
        run_random(100, 1'b0);
        finish_phase();

        // random with idling, starting under a long receiver hold-off
        write_cfg(CFG_FAIR_MODE, 8'd1);
        write_cfg(CFG_TRUSTED_REPEAT, 8'($urandom_range(2, 254)));
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
        hold_off_req = 1'b1;
        run_random(100, 1'b0);
        finish_phase();

        // fill the table until the rolling id runs onto live slots
        write_cfg(CFG_FAIR_MODE, 8'($urandom_range(0, 1)));
        write_cfg(CFG_DROP_IPV6, 8'd0);
        write_cfg(CFG_TRUSTED_REPEAT, 8'd255);
        run_random(1300, 1'b1);
        finish_phase();

        // mixed traffic against a crowded table
        write_cfg(CFG_FAIR_MODE, 8'd0);
        write_cfg(CFG_TRUSTED_REPEAT, 8'($urandom_range(2, 254)));
        run_random(100, 1'b0);
        finish_phase();

        if (sb.errors == 0) begin
            $display("PASS dual_upstream_reply_selector");
        end else begin
            $display("FAIL dual_upstream_reply_selector");
        end
        $finish;
    end

endmodule

FILE: files.f
design/durs_pkg.sv
design/durs_ctrl.sv
design/durs_datapath.sv
design/dual_upstream_reply_selector.sv
test/tb_dual_upstream_reply_selector.sv
